// ===== design/remote_frame_checker_defines.svh =====
// Assertion macros used by the port-level assertions of the remote frame checker.
`ifndef REMOTE_FRAME_CHECKER_DEFINES_SVH
`define REMOTE_FRAME_CHECKER_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define RFC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define RFC_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== design/rfc_pkg.sv =====
// Package with the constants, types and header function of the remote frame checker.
`timescale 1ns / 1ps
`default_nettype none

package rfc_pkg;

   // Frame layout.
   localparam int unsigned PAYLOAD_BYTES = 32;
   localparam int unsigned POS_W         = 6;
   localparam int unsigned SUM_W         = 12;
   localparam int unsigned SUM_BYTES     = 13;
   localparam int unsigned HEADER_BYTES  = 3;
   localparam int unsigned STICK_FIRST   = 3;
   localparam int unsigned STICK_BYTES   = 8;
   localparam int unsigned SWITCH_FIRST  = 11;
   localparam int unsigned SWITCH_BYTES  = 2;
   localparam int unsigned CHECK_FIRST   = 13;
   localparam int unsigned CHECK_BYTES   = 4;
   localparam int unsigned CHECK_W       = 32;

   // Port widths.
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned REQ_DATA_W   = 8;
   localparam int unsigned RSP_FIELDS_W = 83;
   localparam int unsigned RSP_DATA_W   = 88;
   localparam int unsigned RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned CSR_DATA_W   = 8;

   localparam logic [BYTE_W-1:0] HEAD_SLOW_RESET = 8'd115;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_HEADER = 2'd1,
      STATUS_BAD_SUM    = 2'd2
   } status_type;

   // Header classification while a frame is taken in.
   typedef enum logic [1:0] {
      HDR_NONE   = 2'd0,
      HDR_NORMAL = 2'd1,
      HDR_SLOW   = 2'd2
   } hdr_class_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEAD_ONE    = 2'd0,
      CSR_HEAD_TWO    = 2'd1,
      CSR_HEAD_NORMAL = 2'd2,
      CSR_HEAD_SLOW   = 2'd3
   } csr_index_type;

   // Expected header bytes.
   typedef struct packed {
      logic [BYTE_W-1:0] one;
      logic [BYTE_W-1:0] two;
      logic [BYTE_W-1:0] normal;
      logic [BYTE_W-1:0] slow;
   } head_cfg_type;

   // One header byte at position 0, 1 or 2 updates the classification.
   function automatic hdr_class_type hdr_step(input logic [1:0] pos,
                                              input hdr_class_type cls,
                                              input logic [BYTE_W-1:0] b,
                                              input head_cfg_type cfg);
      hdr_class_type res;
      case (pos)
         2'd0: begin
            res = (b == cfg.one) ? HDR_NORMAL : HDR_NONE;
         end
         2'd1: begin
            res = (cls == HDR_NORMAL && b == cfg.two) ? HDR_NORMAL : HDR_NONE;
         end
         2'd2: begin
            if (cls == HDR_NORMAL && b == cfg.normal) begin
               res = HDR_NORMAL;
            end else if (cls == HDR_NORMAL && b == cfg.slow) begin
               res = HDR_SLOW;
            end else begin
               res = HDR_NONE;
            end
         end
         default: begin
            res = cls;
         end
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== design/remote_frame_checker.sv =====
// Top level of the remote frame checker: byte intake, frame check and result register.
//
// Usage:
// The req channel carries one payload byte per word in req_tdata; req_tlast marks the
// last byte of a frame. Only the last word of a frame produces a result on the rsp
// channel: a status (accepted, header mismatch, checksum mismatch), the stick and
// switch values of the last accepted frame and the slow-descent flag.
// The csr port writes the four expected header bytes; write them only while idle.
// The last byte goes via the input register and frame logic into the result register.
// Throughput: one byte per cycle, set by the single frame update stage, as long as no
// frame end waits in the input register for a stalled result.
// When the receiver stalls, the result holds in its register; bytes that do not end
// a frame keep flowing, and the next last byte waits in the input register, which
// then holds req_tready low until the waiting result is taken.
// Reset clears the frame state, the accepted fields, the slow flag and the header
// registers (the slow-descent header byte resets to 115).
// Bytes at or beyond PAYLOAD_BYTES are ignored; missing bytes count as zero.
`timescale 1ns / 1ps
`default_nettype none

module remote_frame_checker (
   input  logic                              clock,
   input  logic                              reset,
   // Input words.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rfc_pkg::REQ_DATA_W-1:0]    req_tdata,  // [7:0] byte_value
   input  logic                              req_tlast,  // frame_end
   // Result words.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] status, [17:2] throttle, [33:18] yaw, [49:34] pitch, [65:50] roll,
   // [73:66] shutdown_cmd, [81:74] hold_height_cmd, [82] slow_descent, rest zero
   output logic [rfc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Configuration writes.
   input  logic                              csr_wr_en,
   input  logic [rfc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rfc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rfc_pkg::*;

   // Configuration registers.
   head_cfg_type cfg_ff, cfg_in;

   // Input register.
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              in_last_ff, in_last_in;
   logic              advance;

   // Frame state.
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   hdr_class_type     hdr_ff, hdr_in;
   logic [BYTE_W-1:0] stick_ff [STICK_BYTES];
   logic [BYTE_W-1:0] stick_in [STICK_BYTES];
   logic [BYTE_W-1:0] switch_ff [SWITCH_BYTES];
   logic [BYTE_W-1:0] switch_in [SWITCH_BYTES];
   logic [BYTE_W-1:0] chk_ff [CHECK_BYTES];
   logic [BYTE_W-1:0] chk_in [CHECK_BYTES];

   // Accepted fields and result.
   logic [BYTE_W-1:0] acc_stick_ff [STICK_BYTES];
   logic [BYTE_W-1:0] acc_stick_in [STICK_BYTES];
   logic [BYTE_W-1:0] acc_switch_ff [SWITCH_BYTES];
   logic [BYTE_W-1:0] acc_switch_in [SWITCH_BYTES];
   logic              slow_ff, slow_in;
   status_type        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Values after the current byte.
   logic              cur_in;
   logic [POS_W-1:0]  pos_step;
   logic [SUM_W-1:0]  sum_step;
   hdr_class_type     hdr_step_val;
   hdr_class_type     hdr_fin;
   logic [BYTE_W-1:0] stick_step [STICK_BYTES];
   logic [BYTE_W-1:0] switch_step [SWITCH_BYTES];
   logic [BYTE_W-1:0] chk_step [CHECK_BYTES];
   logic [CHECK_W-1:0] chk_word;
   status_type        status_fin;

   // Handshake: a frame end only moves on when the result register is free.
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata[BYTE_W-1:0];
         in_last_in  = req_tlast;
      end
   end

   // Configuration writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_HEAD_ONE:    cfg_in.one    = csr_wdata[BYTE_W-1:0];
            CSR_HEAD_TWO:    cfg_in.two    = csr_wdata[BYTE_W-1:0];
            CSR_HEAD_NORMAL: cfg_in.normal = csr_wdata[BYTE_W-1:0];
            CSR_HEAD_SLOW:   cfg_in.slow   = csr_wdata[BYTE_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Absorb the current byte at its position; each capture byte has its own slot.
   always_comb begin
      cur_in   = pos_ff < POS_W'(PAYLOAD_BYTES);
      pos_step = cur_in ? pos_ff + POS_W'(1) : pos_ff;
      sum_step = (cur_in && pos_ff < POS_W'(SUM_BYTES)) ?
                 sum_ff + SUM_W'(in_byte_ff) : sum_ff;
      hdr_step_val = (cur_in && pos_ff < POS_W'(HEADER_BYTES)) ?
                     hdr_step(pos_ff[1:0], hdr_ff, in_byte_ff, cfg_ff) : hdr_ff;
      for (int i = 0; i < STICK_BYTES; i++) begin
         stick_step[i] = (cur_in && pos_ff == POS_W'(STICK_FIRST + i)) ?
                         in_byte_ff : stick_ff[i];
      end
      for (int i = 0; i < SWITCH_BYTES; i++) begin
         switch_step[i] = (cur_in && pos_ff == POS_W'(SWITCH_FIRST + i)) ?
                          in_byte_ff : switch_ff[i];
      end
      for (int i = 0; i < CHECK_BYTES; i++) begin
         chk_step[i] = (cur_in && pos_ff == POS_W'(CHECK_FIRST + i)) ?
                       in_byte_ff : chk_ff[i];
      end
   end

   // Frame end: header positions never reached are classified as zero bytes.
   always_comb begin
      hdr_fin = hdr_step_val;
      for (int k = 0; k < HEADER_BYTES; k++) begin
         if (pos_step <= POS_W'(k)) begin
            hdr_fin = hdr_step(2'(k), hdr_fin, '0, cfg_ff);
         end
      end
      chk_word = {chk_step[0], chk_step[1], chk_step[2], chk_step[3]};
      if (hdr_fin == HDR_NONE) begin
         status_fin = STATUS_BAD_HEADER;
      end else if (CHECK_W'(sum_step) != chk_word) begin
         status_fin = STATUS_BAD_SUM;
      end else begin
         status_fin = STATUS_OK;
      end
   end

   // Next state of the frame, the accepted fields and the result register.
   always_comb begin
      pos_in        = pos_ff;
      sum_in        = sum_ff;
      hdr_in        = hdr_ff;
      stick_in      = stick_ff;
      switch_in     = switch_ff;
      chk_in        = chk_ff;
      acc_stick_in  = acc_stick_ff;
      acc_switch_in = acc_switch_ff;
      slow_in       = slow_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (advance) begin
         if (in_last_ff) begin
            pos_in       = '0;
            sum_in       = '0;
            hdr_in       = HDR_NONE;
            for (int i = 0; i < STICK_BYTES; i++) begin
               stick_in[i] = '0;
            end
            for (int i = 0; i < SWITCH_BYTES; i++) begin
               switch_in[i] = '0;
            end
            for (int i = 0; i < CHECK_BYTES; i++) begin
               chk_in[i] = '0;
            end
            status_in    = status_fin;
            rsp_valid_in = 1'b1;
            if (status_fin == STATUS_OK) begin
               acc_stick_in  = stick_step;
               acc_switch_in = switch_step;
               slow_in       = (hdr_fin == HDR_SLOW);
            end
         end else begin
            pos_in    = pos_step;
            sum_in    = sum_step;
            hdr_in    = hdr_step_val;
            stick_in  = stick_step;
            switch_in = switch_step;
            chk_in    = chk_step;
         end
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one    <= '0;
         cfg_ff.two    <= '0;
         cfg_ff.normal <= '0;
         cfg_ff.slow   <= HEAD_SLOW_RESET;
         in_valid_ff   <= 1'b0;
         pos_ff        <= '0;
         sum_ff        <= '0;
         hdr_ff        <= HDR_NONE;
         for (int i = 0; i < STICK_BYTES; i++) begin
            stick_ff[i]     <= '0;
            acc_stick_ff[i] <= '0;
         end
         for (int i = 0; i < SWITCH_BYTES; i++) begin
            switch_ff[i]     <= '0;
            acc_switch_ff[i] <= '0;
         end
         for (int i = 0; i < CHECK_BYTES; i++) begin
            chk_ff[i] <= '0;
         end
         slow_ff       <= 1'b0;
         status_ff     <= STATUS_OK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         in_valid_ff   <= in_valid_in;
         pos_ff        <= pos_in;
         sum_ff        <= sum_in;
         hdr_ff        <= hdr_in;
         stick_ff      <= stick_in;
         acc_stick_ff  <= acc_stick_in;
         switch_ff     <= switch_in;
         acc_switch_ff <= acc_switch_in;
         chk_ff        <= chk_in;
         slow_ff       <= slow_in;
         status_ff     <= status_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Input payload needs no reset.
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   // Result word, built from the status and the accepted fields.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, slow_ff,
                        acc_switch_ff[1], acc_switch_ff[0],
                        acc_stick_ff[6], acc_stick_ff[7],
                        acc_stick_ff[4], acc_stick_ff[5],
                        acc_stick_ff[2], acc_stick_ff[3],
                        acc_stick_ff[0], acc_stick_ff[1],
                        status_ff};

endmodule

`default_nettype wire

// ===== design/rfc_checker.sv =====
// Port-level assertions of the remote frame checker and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "remote_frame_checker_defines.svh"

module rfc_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            req_tlast,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [rfc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import rfc_pkg::*;

   logic                    rsp_stall;
   logic                    frame_end_taken;
   logic                    rsp_rejected;
   logic [RSP_FIELDS_W-3:0] kept_fields;

   // Handshake and result conditions seen on the ports.
   assign rsp_stall       = rsp_tvalid && !rsp_tready;
   assign frame_end_taken = req_tvalid && req_tready && req_tlast;
   assign rsp_rejected    = rsp_tvalid && (rsp_tdata[1:0] != STATUS_OK);
   assign kept_fields     = rsp_tdata[RSP_FIELDS_W-1:2];

   // A stalled result word stays offered.
   `RFC_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid, "result word dropped while stalled")

   // A stalled result word keeps its value.
   `RFC_ASSERT(a_rsp_stable, rsp_stall |=> $stable(rsp_tdata), "stalled result word changed")

   // A new result follows the word that ended its frame, via the input and result registers.
   `RFC_ASSERT(a_rsp_latency, $rose(rsp_tvalid) |-> $past(frame_end_taken, 2), "late result")

   // Input back-pressure only comes from a waiting result.
   `RFC_NEVER(a_ready_cause, !req_tready && !rsp_stall, "input stalled without a waiting result")

   // A rejected frame leaves the accepted fields and the slow flag as they were.
   `RFC_ASSERT(a_reject_keeps, rsp_rejected |-> $stable(kept_fields), "rejected frame changed fields")

endmodule

bind remote_frame_checker rfc_checker u_rfc_checker (.*);

`default_nettype wire

// ===== tb/remote_frame_checker_test.sv =====
// Self-checking testbench for the remote frame checker: random frames against a byte-level predictor.
`timescale 1ns / 1ps

module remote_frame_checker_test;
   import rfc_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SHOWN_ERRORS  = 10;
   localparam int unsigned IDLE_PERCENT  = 12;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned FRAME_MAX     = 40;
   localparam int unsigned CHECK_END     = CHECK_FIRST + CHECK_BYTES;

   // Kinds of frames that the random part builds.
   typedef enum int {
      FRAME_NORMAL,
      FRAME_SLOW,
      FRAME_BAD_SUM,
      FRAME_BAD_HEAD,
      FRAME_SHORT,
      FRAME_LONG,
      FRAME_NOISE
   } frame_kind_type;

   // One input word.
   typedef struct {
      logic [BYTE_W-1:0] value;
      logic              last;
   } payload_word_type;

   // One result word, unpacked.
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] throttle;
      logic [15:0] yaw;
      logic [15:0] pitch;
      logic [15:0] roll;
      logic [7:0]  shutdown_cmd;
      logic [7:0]  hold_height_cmd;
      logic        slow_descent;
   } frame_verdict_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_wr_en  = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // Words waiting for the driver and verdicts waiting for the block.
   payload_word_type  outgoing_bytes[$];
   frame_verdict_type awaited_verdicts[$];

   int unsigned cycles        = 0;
   int unsigned mismatches    = 0;
   int unsigned queued_bytes  = 0;
   int unsigned queued_frames = 0;
   bit          steady        = 1'b0;

   // Predictor state: header registers, per-frame state and accepted fields.
   head_cfg_type      head_cfg;
   int unsigned       frame_pos;
   logic [SUM_W-1:0]  frame_sum;
   logic [31:0]       frame_check;
   hdr_class_type     frame_hdr;
   logic [63:0]       frame_sticks;
   logic [15:0]       frame_switches;
   logic [63:0]       kept_sticks;
   logic [15:0]       kept_switches;
   logic              kept_slow;

   remote_frame_checker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Per-frame state goes back to zero at every frame boundary.
   function automatic void clear_frame_state();
      frame_pos      = 0;
      frame_sum      = '0;
      frame_check    = '0;
      frame_hdr      = HDR_NONE;
      frame_sticks   = '0;
      frame_switches = '0;
   endfunction

   // Fold one byte at a given frame position into the frame state.
   function automatic void fold_byte(int unsigned pos, logic [BYTE_W-1:0] b);
      if (pos < SUM_BYTES) begin
         frame_sum = frame_sum + SUM_W'(b);
      end
      if (pos == 0) begin
         frame_hdr = (b == head_cfg.one) ? HDR_NORMAL : HDR_NONE;
      end else if (pos == 1) begin
         if (!(frame_hdr == HDR_NORMAL && b == head_cfg.two)) begin
            frame_hdr = HDR_NONE;
         end
      end else if (pos == 2) begin
         // The normal code is tested first, so it wins when both codes are equal.
         if (frame_hdr != HDR_NORMAL) begin
            frame_hdr = HDR_NONE;
         end else if (b == head_cfg.normal) begin
            frame_hdr = HDR_NORMAL;
         end else if (b == head_cfg.slow) begin
            frame_hdr = HDR_SLOW;
         end else begin
            frame_hdr = HDR_NONE;
         end
      end else if (pos < SWITCH_FIRST) begin
         frame_sticks = {frame_sticks[55:0], b};
      end else if (pos < CHECK_FIRST) begin
         frame_switches = {frame_switches[7:0], b};
      end else if (pos < CHECK_END) begin
         frame_check = {frame_check[23:0], b};
      end
   endfunction

   // Take one accepted word; on the last byte of a frame, record the verdict it causes.
   function automatic void take_payload_byte(logic [BYTE_W-1:0] b, logic last);
      frame_verdict_type verdict;
      status_type        status;
      if (frame_pos < PAYLOAD_BYTES) begin
         fold_byte(frame_pos, b);
         frame_pos++;
      end
      if (last) begin
         // A short frame is padded with zero bytes up to the end of the checksum.
         for (int unsigned p = frame_pos; p < CHECK_END; p++) begin
            fold_byte(p, '0);
         end
         if (frame_hdr == HDR_NONE) begin
            status = STATUS_BAD_HEADER;
         end else if (32'(frame_sum) != frame_check) begin
            status = STATUS_BAD_SUM;
         end else begin
            status = STATUS_OK;
         end
         if (status == STATUS_OK) begin
            kept_sticks   = frame_sticks;
            kept_switches = frame_switches;
            kept_slow     = (frame_hdr == HDR_SLOW);
         end
         verdict.status          = status;
         verdict.throttle        = kept_sticks[63:48];
         verdict.yaw             = kept_sticks[47:32];
         verdict.pitch           = kept_sticks[31:16];
         verdict.roll            = kept_sticks[15:0];
         verdict.shutdown_cmd    = kept_switches[15:8];
         verdict.hold_height_cmd = kept_switches[7:0];
         verdict.slow_descent    = kept_slow;
         awaited_verdicts.push_back(verdict);
         clear_frame_state();
      end
   endfunction

   function automatic void report_mismatch(string what, frame_verdict_type want,
                                           frame_verdict_type got);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS) begin
         $display("%0t %s: expected st=%0d thr=%h yaw=%h pit=%h rol=%h sd=%h hh=%h sl=%b",
                  $realtime, what, want.status, want.throttle, want.yaw, want.pitch,
                  want.roll, want.shutdown_cmd, want.hold_height_cmd, want.slow_descent);
         $display("%0t %s: actual   st=%0d thr=%h yaw=%h pit=%h rol=%h sd=%h hh=%h sl=%b",
                  $realtime, what, got.status, got.throttle, got.yaw, got.pitch,
                  got.roll, got.shutdown_cmd, got.hold_height_cmd, got.slow_descent);
      end
   endfunction

   function automatic void queue_byte(logic [BYTE_W-1:0] b, logic last);
      payload_word_type w;
      w.value = b;
      w.last  = last;
      outgoing_bytes.push_back(w);
      queued_bytes++;
      if (last) begin
         queued_frames++;
      end
   endfunction

   // Build one frame of the given kind from the current header registers.
   function automatic void queue_frame(frame_kind_type kind);
      logic [BYTE_W-1:0] bytes[FRAME_MAX];
      logic [SUM_W-1:0]  sum;
      int unsigned       len;
      int unsigned       p;
      sum      = '0;
      len      = CHECK_END;
      bytes[0] = head_cfg.one;
      bytes[1] = head_cfg.two;
      bytes[2] = (kind == FRAME_SLOW || $urandom_range(1) == 1) ? head_cfg.slow
                                                                 : head_cfg.normal;
      if (kind == FRAME_NORMAL) begin
         bytes[2] = head_cfg.normal;
      end
      for (int unsigned i = HEADER_BYTES; i < FRAME_MAX; i++) begin
         bytes[i] = BYTE_W'($urandom_range(255));
      end
      for (int unsigned i = 0; i < SUM_BYTES; i++) begin
         sum = sum + SUM_W'(bytes[i]);
      end
      bytes[13] = '0;
      bytes[14] = '0;
      bytes[15] = {4'h0, sum[11:8]};
      bytes[16] = sum[7:0];
      case (kind)
         FRAME_BAD_SUM: begin
            p = CHECK_FIRST + $urandom_range(CHECK_BYTES - 1);
            bytes[p] = bytes[p] ^ (8'h01 << $urandom_range(7));
         end
         FRAME_BAD_HEAD: begin
            p = $urandom_range(HEADER_BYTES - 1);
            bytes[p] = bytes[p] ^ BYTE_W'($urandom_range(255, 1));
         end
         FRAME_SHORT: begin
            len = $urandom_range(CHECK_END - 1, 1);
         end
         FRAME_LONG: begin
            len = $urandom_range(FRAME_MAX, CHECK_END + 1);
         end
         FRAME_NOISE: begin
            len = $urandom_range(24, 1);
            for (int unsigned i = 0; i < HEADER_BYTES; i++) begin
               bytes[i] = BYTE_W'($urandom_range(255));
            end
         end
         default: begin
         end
      endcase
      for (int unsigned i = 0; i < len; i++) begin
         queue_byte(bytes[i], i == len - 1);
      end
   endfunction

   function automatic frame_kind_type pick_frame_kind();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 25) begin
         return FRAME_NORMAL;
      end else if (r < 50) begin
         return FRAME_SLOW;
      end else if (r < 62) begin
         return FRAME_BAD_SUM;
      end else if (r < 72) begin
         return FRAME_BAD_HEAD;
      end else if (r < 82) begin
         return FRAME_SHORT;
      end else if (r < 92) begin
         return FRAME_LONG;
      end
      return FRAME_NOISE;
   endfunction

   // Called just after a rising edge; the write lands at the next one.
   task automatic write_header_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_HEAD_ONE: begin
            head_cfg.one = value;
         end
         CSR_HEAD_TWO: begin
            head_cfg.two = value;
         end
         CSR_HEAD_NORMAL: begin
            head_cfg.normal = value;
         end
         default: begin
            head_cfg.slow = value;
         end
      endcase
      @(posedge clock);
   endtask

   task automatic set_headers(logic [7:0] one, logic [7:0] two, logic [7:0] normal,
                              logic [7:0] slow);
      write_header_reg(CSR_HEAD_ONE, one);
      write_header_reg(CSR_HEAD_TWO, two);
      write_header_reg(CSR_HEAD_NORMAL, normal);
      write_header_reg(CSR_HEAD_SLOW, slow);
      csr_wr_en <= 1'b0;
   endtask

   // Wait until every word is sent and every verdict is in, then let the pipeline drain.
   task automatic wait_drained();
      while (outgoing_bytes.size() != 0 || awaited_verdicts.size() != 0 || req_tvalid) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_frames(int unsigned n_bytes, int unsigned n_frames);
      int unsigned byte_goal;
      int unsigned frame_goal;
      byte_goal  = queued_bytes + n_bytes;
      frame_goal = queued_frames + n_frames;
      while (queued_bytes < byte_goal || queued_frames < frame_goal) begin
         queue_frame(pick_frame_kind());
      end
      wait_drained();
   endtask

   // Driver: next word after each handshake, with random gaps.
   always @(posedge clock) begin : drive_bytes
      payload_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            take_payload_byte(req_tdata, req_tlast);
         end
         if (!req_tvalid || req_tready) begin
            if (outgoing_bytes.size() != 0 &&
                (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
               w = outgoing_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= w.value;
               req_tlast  <= w.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random back-pressure, each verdict checked against the oldest expectation.
   always @(posedge clock) begin : watch_verdicts
      frame_verdict_type got;
      frame_verdict_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.status          = rsp_tdata[1:0];
            got.throttle        = rsp_tdata[17:2];
            got.yaw             = rsp_tdata[33:18];
            got.pitch           = rsp_tdata[49:34];
            got.roll            = rsp_tdata[65:50];
            got.shutdown_cmd    = rsp_tdata[73:66];
            got.hold_height_cmd = rsp_tdata[81:74];
            got.slow_descent    = rsp_tdata[82];
            if (awaited_verdicts.size() == 0) begin
               report_mismatch("unexpected word", '0, got);
            end else begin
               want = awaited_verdicts.pop_front();
               if (got.status !== want.status || got.throttle !== want.throttle ||
                   got.yaw !== want.yaw || got.pitch !== want.pitch ||
                   got.roll !== want.roll || got.shutdown_cmd !== want.shutdown_cmd ||
                   got.hold_height_cmd !== want.hold_height_cmd ||
                   got.slow_descent !== want.slow_descent) begin
                  report_mismatch("mismatch", want, got);
               end
            end
         end
      end
   end

   // Stimulus: reset, directed frames, then random frames under several header settings.
   initial begin
      head_cfg    = '{one: 8'h00, two: 8'h00, normal: 8'h00, slow: HEAD_SLOW_RESET};
      kept_sticks   = '0;
      kept_switches = '0;
      kept_slow     = 1'b0;
      clear_frame_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // All-zero header with the reset slow code.
      set_headers(8'h00, 8'h00, 8'h00, HEAD_SLOW_RESET);
      @(posedge clock);
      // One-byte frame with a wrong first byte.
      queue_byte(8'hFF, 1'b1);
      // Header-only frame: missing bytes count as zero, so the zero sum matches.
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b1);
      // Full slow-descent frame with all sticks and switches at their maximum.
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(HEAD_SLOW_RESET, 1'b0);
      for (int i = 0; i < 10; i++) begin
         queue_byte(8'hFF, 1'b0);
      end
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h0A, 1'b0);
      queue_byte(8'h69, 1'b1);
      // Normal header with a nonzero sum but a missing checksum.
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h01, 1'b1);
      wait_drained();
      run_random_frames(80, 6);

      // Random header bytes.
      set_headers(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
      run_random_frames(120, 10);

      // All ones: both third-byte codes equal, so the normal header wins.
      set_headers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      run_random_frames(80, 6);

      // Random header bytes with no idling on either side.
      steady = 1'b1;
      set_headers(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
      run_random_frames(120, 10);
      steady = 1'b0;

      // Random header bytes again, with idling.
      set_headers(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
      run_random_frames(120, 10);

      if (mismatches == 0 && awaited_verdicts.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== remote_frame_checker.f =====
+incdir+design
design/rfc_pkg.sv
design/remote_frame_checker.sv
design/rfc_checker.sv
tb/remote_frame_checker_test.sv
